// File: src/frame_timer_pool_defines.svh
// Assertion helpers for the timer pool.
`ifndef FRAME_TIMER_POOL_DEFINES_SVH
`define FRAME_TIMER_POOL_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define FTP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame_timer_pool: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define FTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame_timer_pool: next-cycle check failed");

`endif

// File: src/ftp_pkg.sv
package ftp_pkg;

   localparam logic [2:0] OP_CREATE  = 3'd0;
   localparam logic [2:0] OP_START   = 3'd1;
   localparam logic [2:0] OP_REMOVE  = 3'd2;
   localparam logic [2:0] OP_ADVANCE = 3'd3;
   localparam logic [2:0] OP_TICK    = 3'd4;

   localparam logic [2:0] KIND_CREATE = 3'd0;
   localparam logic [2:0] KIND_START  = 3'd1;
   localparam logic [2:0] KIND_REMOVE = 3'd2;
   localparam logic [2:0] KIND_EXPIRY = 3'd3;
   localparam logic [2:0] KIND_DONE   = 3'd4;

   localparam logic [1:0] TYPE_ONCE   = 2'd0;
   localparam logic [1:0] TYPE_LOOP   = 2'd1;
   localparam logic [1:0] TYPE_REPEAT = 2'd2;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic        notify;
      logic [30:0] duration;
   } slot_cfg_type;

   typedef struct packed {
      logic cfg_we;
      logic start_we;
   } slot_wr_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

endpackage

// File: src/ftp_expiry_unit.sv
// Shared compare: signed elapsed frames against the slot duration.
module ftp_expiry_unit (
   input  logic [31:0] frame_value,
   input  logic [31:0] start_stamp,
   input  logic [30:0] duration,
   output logic        expired
);

   logic [31:0] elapsed;

   assign elapsed = frame_value - start_stamp;
   // negative elapsed never expires
   assign expired = !elapsed[31] && (elapsed[30:0] > duration);

endmodule

// File: src/ftp_slot_store.sv
module ftp_slot_store #(
   parameter int NUM_SLOTS = 16,
   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  logic                 clock,
   input  ftp_pkg::slot_wr_type wr,
   input  logic [IW-1:0]        cfg_addr,
   input  ftp_pkg::slot_cfg_type cfg_data,
   input  logic [IW-1:0]        start_addr,
   input  logic [31:0]          start_data,
   input  logic [IW-1:0]        rd_addr,
   output ftp_pkg::slot_cfg_type rd_cfg,
   output logic [31:0]          rd_start
);

   ftp_pkg::slot_cfg_type cfg_mem_ff [NUM_SLOTS];
   logic [31:0]           start_mem_ff [NUM_SLOTS];
   ftp_pkg::slot_cfg_type rd_cfg_ff;
   logic [31:0]           rd_start_ff;

   always_ff @(posedge clock) begin
      if (wr.cfg_we) begin
         cfg_mem_ff[cfg_addr] <= cfg_data;
      end
      if (wr.start_we) begin
         start_mem_ff[start_addr] <= start_data;
      end
      rd_cfg_ff   <= cfg_mem_ff[rd_addr];
      rd_start_ff <= start_mem_ff[rd_addr];
   end

   assign rd_cfg   = rd_cfg_ff;
   assign rd_start = rd_start_ff;

endmodule

// File: src/ftp_free_stack.sv
// LIFO of freed slot numbers; top of stack is registered and comes out in the cycle after the count settles.
module ftp_free_stack #(
   parameter int NUM_SLOTS = 16,
   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
   localparam int CW = $clog2(NUM_SLOTS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ftp_pkg::stack_ctl_type ctl,
   input  logic [IW-1:0]          push_data,
   output logic [CW-1:0]          count,
   output logic [IW-1:0]          top
);

   logic [IW-1:0] stack_mem_ff [NUM_SLOTS];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [IW-1:0] top_ff;
   logic [IW-1:0] rd_addr;

   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CW'(1);
      end
      rd_addr = (count_ff == '0) ? '0 : IW'(count_ff - CW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         stack_mem_ff[count_ff[IW-1:0]] <= push_data;
      end
      top_ff <= stack_mem_ff[rd_addr];
   end

   assign count = count_ff;
   assign top   = top_ff;

endmodule

// File: src/frame_timer_pool.sv
// Pool of frame-driven timer slots. Pulse start while busy is low to hand in one
// command; each result appears for exactly one cycle with rsp_valid high and cannot
// be held off, so the receiver must take it then. Start, remove, advance and unknown
// opcodes pass through S_EXEC before the next command can be accepted, create passes
// through S_CRD (for the free-stack read) and S_CWR, and tick through S_TICK and
// S_DONE: the slot memory has one read port, so the tick walks the used slots one
// per cycle, then sends done. Expiry events of a tick come in slot order with
// rsp_last low; the final result of every command has rsp_last high. rsp_frame_now
// shows the frame counter after the command. No clearing pass is needed after reset.
`include "frame_timer_pool_defines.svh"

module frame_timer_pool #(
   parameter int NUM_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [3:0]  req_slot,
   input  logic [1:0]  req_timer_type,
   input  logic [30:0] req_duration,
   input  logic        req_notify,
   input  logic [31:0] req_frame_value,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [3:0]  rsp_slot_out,
   output logic        rsp_status,
   output logic [31:0] rsp_frame_now,
   output logic        rsp_last
);

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam logic [CW-1:0] NUM_CNT = CW'(NUM_SLOTS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_CRD  = 3'd2;
   localparam logic [2:0] S_CWR  = 3'd3;
   localparam logic [2:0] S_TICK = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  op_ff, op_in;
   logic [3:0]  slot_ff, slot_in;
   logic [1:0]  type_ff, type_in;
   logic [30:0] dur_ff, dur_in;
   logic        notify_ff, notify_in;
   logic [31:0] fv_ff, fv_in;

   logic [CW-1:0]        used_cnt_ff, used_cnt_in;
   logic [31:0]          frame_cnt_ff, frame_cnt_in;
   logic [NUM_SLOTS-1:0] enabled_ff, enabled_in;
   logic [NUM_SLOTS-1:0] running_ff, running_in;
   logic [CW-1:0]        rd_ff, rd_in;
   logic                 ev_vld_ff, ev_vld_in;
   logic [IW-1:0]        ev_idx_ff, ev_idx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic        rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_frame_ff, rsp_frame_in;
   logic        rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic                   s_in_range;
   logic [IW-1:0]          idx_s;
   logic [IW-1:0]          pick;
   logic                   expired;
   ftp_pkg::slot_wr_type   slot_wr;
   ftp_pkg::slot_cfg_type  cfg_wdata;
   ftp_pkg::slot_cfg_type  rd_cfg;
   logic [IW-1:0]          start_addr;
   logic [31:0]            start_wdata;
   logic [IW-1:0]          rd_addr;
   logic [31:0]            rd_start;
   ftp_pkg::stack_ctl_type stack_ctl;
   logic [IW-1:0]          push_data;
   logic [CW-1:0]          free_cnt;
   logic [IW-1:0]          free_top;

   ftp_slot_store #(.NUM_SLOTS(NUM_SLOTS)) u_store (
      .clock      (clock),
      .wr         (slot_wr),
      .cfg_addr   (pick),
      .cfg_data   (cfg_wdata),
      .start_addr (start_addr),
      .start_data (start_wdata),
      .rd_addr    (rd_addr),
      .rd_cfg     (rd_cfg),
      .rd_start   (rd_start)
   );

   ftp_free_stack #(.NUM_SLOTS(NUM_SLOTS)) u_stack (
      .clock     (clock),
      .reset     (reset),
      .ctl       (stack_ctl),
      .push_data (push_data),
      .count     (free_cnt),
      .top       (free_top)
   );

   ftp_expiry_unit u_expiry (
      .frame_value (fv_ff),
      .start_stamp (rd_start),
      .duration    (rd_cfg.duration),
      .expired     (expired)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign s_in_range = (32'(slot_ff) < 32'(NUM_SLOTS));
   assign idx_s      = IW'(slot_ff);
   assign rd_addr    = (rd_ff < used_cnt_ff) ? rd_ff[IW-1:0] : '0;

   assign cfg_wdata.kind     = type_ff;
   assign cfg_wdata.notify   = notify_ff;
   assign cfg_wdata.duration = dur_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      slot_in      = slot_ff;
      type_in      = type_ff;
      dur_in       = dur_ff;
      notify_in    = notify_ff;
      fv_in        = fv_ff;
      used_cnt_in  = used_cnt_ff;
      frame_cnt_in = frame_cnt_ff;
      enabled_in   = enabled_ff;
      running_in   = running_ff;
      rd_in        = rd_ff;
      ev_vld_in    = ev_vld_ff;
      ev_idx_in    = ev_idx_ff;

      rsp_valid_in  = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      pick           = '0;
      slot_wr        = '0;
      start_addr     = idx_s;
      start_wdata    = frame_cnt_ff;
      stack_ctl      = '0;
      push_data      = idx_s;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_opcode;
               slot_in   = req_slot;
               type_in   = req_timer_type;
               dur_in    = req_duration;
               notify_in = req_notify;
               fv_in     = req_frame_value;
               rd_in     = '0;
               ev_vld_in = 1'b0;
               unique case (req_opcode)
                  ftp_pkg::OP_CREATE: state_in = S_CRD;
                  ftp_pkg::OP_TICK:   state_in = S_TICK;
                  default:            state_in = S_EXEC;
               endcase
            end
         end

         S_EXEC: begin
            rsp_valid_in  = 1'b1;
            rsp_slot_in   = slot_ff;
            rsp_status_in = ftp_pkg::STATUS_OK;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
            unique case (op_ff)
               ftp_pkg::OP_START: begin
                  rsp_kind_in = ftp_pkg::KIND_START;
                  if (s_in_range && enabled_ff[idx_s]) begin
                     running_in[idx_s] = 1'b1;
                     slot_wr.start_we  = 1'b1;
                  end else begin
                     rsp_status_in = ftp_pkg::STATUS_ERR;
                  end
               end
               ftp_pkg::OP_REMOVE: begin
                  rsp_kind_in = ftp_pkg::KIND_REMOVE;
                  if (s_in_range && (32'(slot_ff) < 32'(used_cnt_ff)) && enabled_ff[idx_s]) begin
                     enabled_in[idx_s] = 1'b0;
                     running_in[idx_s] = 1'b0;
                     stack_ctl.push    = (free_cnt < NUM_CNT);
                  end else begin
                     rsp_status_in = ftp_pkg::STATUS_ERR;
                  end
               end
               ftp_pkg::OP_ADVANCE: begin
                  rsp_kind_in  = ftp_pkg::KIND_DONE;
                  rsp_slot_in  = '0;
                  frame_cnt_in = frame_cnt_ff + 32'd1;
               end
               default: begin
                  rsp_kind_in   = ftp_pkg::KIND_DONE;
                  rsp_slot_in   = '0;
                  rsp_status_in = ftp_pkg::STATUS_ERR;
               end
            endcase
         end

         S_CRD: begin
            // free stack top is being read this cycle
            state_in = S_CWR;
         end

         S_CWR: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = ftp_pkg::KIND_CREATE;
            rsp_last_in   = 1'b1;
            rsp_status_in = ftp_pkg::STATUS_OK;
            state_in      = S_IDLE;
            if (free_cnt != '0) begin
               pick          = free_top;
               stack_ctl.pop = 1'b1;
            end else if (used_cnt_ff < NUM_CNT) begin
               pick        = used_cnt_ff[IW-1:0];
               used_cnt_in = used_cnt_ff + CW'(1);
            end else begin
               rsp_status_in = ftp_pkg::STATUS_ERR;
            end
            rsp_slot_in = 4'(pick);
            if (rsp_status_in == ftp_pkg::STATUS_OK) begin
               slot_wr.cfg_we   = 1'b1;
               enabled_in[pick] = 1'b1;
               running_in[pick] = 1'b0;
            end
         end

         S_TICK: begin
            // evaluate the slot read last cycle while the next one is read
            if (ev_vld_ff && enabled_ff[ev_idx_ff] && running_ff[ev_idx_ff] && expired) begin
               if (rd_cfg.notify) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = ftp_pkg::KIND_EXPIRY;
                  rsp_slot_in   = 4'(ev_idx_ff);
                  rsp_status_in = ftp_pkg::STATUS_OK;
                  rsp_last_in   = 1'b0;
               end
               case (rd_cfg.kind)
                  ftp_pkg::TYPE_ONCE: begin
                     enabled_in[ev_idx_ff] = 1'b0;
                     running_in[ev_idx_ff] = 1'b0;
                     push_data             = ev_idx_ff;
                     stack_ctl.push        = (free_cnt < NUM_CNT);
                  end
                  ftp_pkg::TYPE_LOOP: begin
                     slot_wr.start_we = 1'b1;
                     start_addr       = ev_idx_ff;
                     start_wdata      = fv_ff;
                  end
                  ftp_pkg::TYPE_REPEAT: begin
                     running_in[ev_idx_ff] = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
            if (rd_ff < used_cnt_ff) begin
               ev_vld_in = 1'b1;
               ev_idx_in = rd_ff[IW-1:0];
               rd_in     = rd_ff + CW'(1);
            end else begin
               ev_vld_in = 1'b0;
               state_in  = S_DONE;
            end
         end

         S_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = ftp_pkg::KIND_DONE;
            rsp_slot_in   = '0;
            rsp_status_in = ftp_pkg::STATUS_OK;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_frame_in = frame_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_cnt_ff  <= '0;
         frame_cnt_ff <= '0;
         enabled_ff   <= '0;
         running_ff   <= '0;
         rd_ff        <= '0;
         ev_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_cnt_ff  <= used_cnt_in;
         frame_cnt_ff <= frame_cnt_in;
         enabled_ff   <= enabled_in;
         running_ff   <= running_in;
         rd_ff        <= rd_in;
         ev_vld_ff    <= ev_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      slot_ff       <= slot_in;
      type_ff       <= type_in;
      dur_ff        <= dur_in;
      notify_ff     <= notify_in;
      fv_ff         <= fv_in;
      ev_idx_ff     <= ev_idx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_slot_out  = rsp_slot_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_frame_now = rsp_frame_ff;
   assign rsp_last      = rsp_last_ff;

   `FTP_ASSERT_SAME(a_free_le_used, clock, reset, 1'b1, free_cnt <= used_cnt_ff)
   `FTP_ASSERT_SAME(a_expiry_not_last, clock, reset, rsp_valid_ff && rsp_kind_ff == ftp_pkg::KIND_EXPIRY, !rsp_last_ff)
   `FTP_ASSERT_SAME(a_last_beat_idle, clock, reset, rsp_valid_ff && rsp_last_ff, state_ff == S_IDLE)
   `FTP_ASSERT_NEXT(a_create_ack, clock, reset, state_ff == S_CWR, rsp_valid_ff && rsp_kind_ff == ftp_pkg::KIND_CREATE)

endmodule
